// ===== rtl/dsn_pkg.sv =====
// Shared types, constants and sigmoid table for the dense sigmoid neuron.
package dsn_pkg;

   localparam int DATA_WIDTH   = 16;
   localparam int FRAC_BITS    = DATA_WIDTH - 4;
   localparam int PROD_WIDTH   = 2 * DATA_WIDTH;
   localparam int PROD_FRAC    = 2 * FRAC_BITS;
   localparam int ACC_WIDTH    = 48;
   localparam int SUM_WIDTH    = ACC_WIDTH + 1;
   localparam int OUT_WIDTH    = 16;
   localparam int SIG_ENTRIES  = 256;
   localparam int SIG_IDX_BITS = $clog2(SIG_ENTRIES);
   // clamp window [-8, 8) in accumulator format: Q4 integer part plus fraction
   localparam int CLAMP_BITS   = PROD_FRAC + 4;

   localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic signed [SUM_WIDTH-1:0] CLAMP_HI =
      SUM_WIDTH'((64'sd1 <<< (CLAMP_BITS - 1)) - 64'sd1);
   localparam logic signed [SUM_WIDTH-1:0] CLAMP_LO =
      SUM_WIDTH'(-(64'sd1 <<< (CLAMP_BITS - 1)));

   // table generation constants, Q2.30
   localparam longint Q30_ONE      = 64'sd1 <<< 30;
   localparam longint Q30_HALF     = 64'sd1 <<< 29;
   localparam longint E_INV_Q30    = 64'sd395007542;
   localparam int     TAYLOR_TERMS = 20;
   localparam int     OUT_MAX      = (1 << OUT_WIDTH) - 1;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] activation;
      logic signed [DATA_WIDTH-1:0] weight;
      logic signed [DATA_WIDTH-1:0] bias;
      logic                         last;
   } req_payload_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] neuron_out;
      logic                 overflowed;
   } rsp_payload_type;

   typedef logic [SIG_ENTRIES-1:0][OUT_WIDTH-1:0] sig_table_type;

   // shift-subtract long division, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [64:0] rem;
      logic [63:0] quo;
      int          b;
      rem = '0;
      quo = '0;
      for (b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sigmoid at the centre of bin i
   function automatic logic [OUT_WIDTH-1:0] sig_entry(input int i);
      longint k;
      longint mag;
      longint t;
      longint n;
      longint f;
      longint term;
      longint sum;
      longint u;
      longint den;
      longint r;
      logic   neg;
      int     j;
      longint m;
      k    = 64'(2 * i + 1 - SIG_ENTRIES);
      neg  = (k < 0);
      mag  = neg ? -k : k;
      t    = longint'(udiv64(64'(mag) << 33, 64'(SIG_ENTRIES)));
      n    = t >>> 30;
      f    = t & (Q30_ONE - 1);
      term = Q30_ONE;
      sum  = Q30_ONE;
      for (j = 1; j <= TAYLOR_TERMS; j++) begin
         term = longint'(udiv64(64'((term * f + Q30_HALF) >>> 30), 64'(j)));
         if (j % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      u = sum;
      for (m = 0; m < n; m++) begin
         u = (u * E_INV_Q30 + Q30_HALF) >>> 30;
      end
      den = Q30_ONE + u;
      if (neg) begin
         r = longint'(udiv64(64'((u <<< 16) + (den >>> 1)), 64'(den)));
      end else begin
         r = longint'(udiv64(64'((64'sd1 <<< 46) + (den >>> 1)), 64'(den)));
      end
      if (r > OUT_MAX) begin
         r = OUT_MAX;
      end
      return r[OUT_WIDTH-1:0];
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tab;
      int            i;
      for (i = 0; i < SIG_ENTRIES; i++) begin
         tab[i] = sig_entry(i);
      end
      return tab;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();

endpackage

// ===== rtl/dense_sigmoid_neuron_top.sv =====
// Dense layer neuron: multiply-accumulate, bias, clamp and sigmoid lookup.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  req     | in        | req_valid / req_stall | activation, weight, bias, last
//  rsp     | out       | rsp_valid / rsp_stall | neuron_out, overflowed (last only)
//
// One item per cycle sustained when nothing is stalled; the accumulator add and saturate sets that rate.
// A result reaches rsp after its last item is accepted by passing through the input register,
// product register, pre-activation register and output register in that order.
// Synchronous reset empties every stage and clears the accumulator and flag.
// Stages move up into empty slots, so items without a result keep flowing while a result
// is held by rsp_stall, until a last item meets a full pre-activation stage.
module dense_sigmoid_neuron_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dsn_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dsn_pkg::rsp_payload_type rsp_payload
);

   // input register
   logic                     a_valid_ff, a_valid_in;
   dsn_pkg::req_payload_type a_item_ff;

   // product register
   logic                                    b_valid_ff, b_valid_in;
   logic signed [dsn_pkg::PROD_WIDTH-1:0]   b_prod_ff;
   logic signed [dsn_pkg::DATA_WIDTH-1:0]   b_bias_ff;
   logic                                    b_last_ff;

   // accumulator
   logic signed [dsn_pkg::ACC_WIDTH-1:0] acc_ff, acc_in;
   logic                                 sat_ff, sat_in;

   // pre-activation register, last items only
   logic                                  d_valid_ff, d_valid_in;
   logic signed [dsn_pkg::ACC_WIDTH-1:0]  d_pre_ff;
   logic signed [dsn_pkg::DATA_WIDTH-1:0] d_bias_ff;
   logic                                  d_ovf_ff;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   dsn_pkg::rsp_payload_type rsp_item_ff, rsp_item_in;

   logic rsp_free, d_load, b_move, b_load, a_load;

   logic signed [dsn_pkg::SUM_WIDTH-1:0]  acc_sum;
   logic                                  acc_ovf;
   logic signed [dsn_pkg::ACC_WIDTH-1:0]  acc_sat;

   logic signed [dsn_pkg::SUM_WIDTH-1:0]  bias_ext;
   logic signed [dsn_pkg::SUM_WIDTH-1:0]  pre_sum;
   logic                                  pre_ovf;
   logic [dsn_pkg::CLAMP_BITS-1:0]        pre_off;
   logic [dsn_pkg::SIG_IDX_BITS-1:0]      sig_idx;

   // flow control, rippling back from the output register
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign d_load    = !d_valid_ff || rsp_free;
   assign b_move    = b_valid_ff && (!b_last_ff || d_load);
   assign b_load    = !b_valid_ff || b_move;
   assign a_load    = !a_valid_ff || b_load;
   assign req_stall = !a_load;

   assign a_valid_in   = a_load ? req_valid : a_valid_ff;
   assign b_valid_in   = b_load ? a_valid_ff : b_valid_ff;
   assign d_valid_in   = d_load ? (b_move && b_last_ff) : d_valid_ff;
   assign rsp_valid_in = rsp_free ? d_valid_ff : rsp_valid_ff;

   // accumulate with saturation at the 48-bit limits
   always_comb begin
      acc_sum = {acc_ff[dsn_pkg::ACC_WIDTH-1], acc_ff}
              + {{(dsn_pkg::SUM_WIDTH - dsn_pkg::PROD_WIDTH){b_prod_ff[dsn_pkg::PROD_WIDTH-1]}},
                 b_prod_ff};
      acc_ovf = acc_sum[dsn_pkg::SUM_WIDTH-1] ^ acc_sum[dsn_pkg::ACC_WIDTH-1];
      if (acc_ovf) begin
         acc_sat = acc_sum[dsn_pkg::SUM_WIDTH-1] ? dsn_pkg::ACC_MIN : dsn_pkg::ACC_MAX;
      end else begin
         acc_sat = acc_sum[dsn_pkg::ACC_WIDTH-1:0];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      sat_in = sat_ff;
      if (b_move) begin
         if (b_last_ff) begin
            acc_in = '0;
            sat_in = 1'b0;
         end else begin
            acc_in = acc_sat;
            sat_in = sat_ff | acc_ovf;
         end
      end
   end

   // bias add, clamp to [-8, 8) and table lookup; clamping the unsaturated sum
   // gives the same index as clamping the saturated one
   always_comb begin
      bias_ext = {{(dsn_pkg::SUM_WIDTH - dsn_pkg::DATA_WIDTH - dsn_pkg::FRAC_BITS)
                   {d_bias_ff[dsn_pkg::DATA_WIDTH-1]}},
                  d_bias_ff, {dsn_pkg::FRAC_BITS{1'b0}}};
      pre_sum  = {d_pre_ff[dsn_pkg::ACC_WIDTH-1], d_pre_ff} + bias_ext;
      pre_ovf  = pre_sum[dsn_pkg::SUM_WIDTH-1] ^ pre_sum[dsn_pkg::ACC_WIDTH-1];
      pre_off  = pre_sum[dsn_pkg::CLAMP_BITS-1:0]
               + {1'b1, {(dsn_pkg::CLAMP_BITS-1){1'b0}}};
      priority if (pre_sum < dsn_pkg::CLAMP_LO) begin
         sig_idx = '0;
      end else if (pre_sum > dsn_pkg::CLAMP_HI) begin
         sig_idx = '1;
      end else begin
         sig_idx = pre_off[dsn_pkg::CLAMP_BITS-1 -: dsn_pkg::SIG_IDX_BITS];
      end
      rsp_item_in.neuron_out = dsn_pkg::SIG_TABLE[sig_idx];
      rsp_item_in.overflowed = d_ovf_ff | pre_ovf;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         sat_ff       <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         d_valid_ff   <= d_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         sat_ff       <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_item_ff <= req_payload;
      end
      if (b_load) begin
         b_prod_ff <= dsn_pkg::PROD_WIDTH'(a_item_ff.activation)
                    * dsn_pkg::PROD_WIDTH'(a_item_ff.weight);
         b_bias_ff <= a_item_ff.bias;
         b_last_ff <= a_item_ff.last;
      end
      if (d_load) begin
         d_pre_ff  <= acc_sat;
         d_bias_ff <= b_bias_ff;
         d_ovf_ff  <= sat_ff | acc_ovf;
      end
      if (rsp_free) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_item_ff;

   // a finished dot product leaves a clean accumulator behind
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (b_move && b_last_ff) |=> (acc_ff == '0 && !sat_ff))
      else $error("accumulator not cleared after last item");

   // the saturation flag is sticky until its dot product completes
   a_sat_sticky: assert property (@(posedge clock) disable iff (reset)
      (sat_ff && !(b_move && b_last_ff)) |=> sat_ff)
      else $error("saturation flag lost mid dot product");

   // a blocked pre-activation stage keeps its item
   a_d_hold: assert property (@(posedge clock) disable iff (reset)
      (d_valid_ff && !d_load) |=> (d_valid_ff && $stable(d_pre_ff)))
      else $error("pre-activation item dropped while blocked");

   // a taken result with nothing behind it leaves the output empty
   a_rsp_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !d_valid_ff) |=> !rsp_valid_ff)
      else $error("result repeated");

endmodule
